// ----- src/ba_pkg.sv -----
// Shared types and constants of the bitmap allocator.
// Depends on nothing; every other file of the block uses it.
package ba_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(MAP_BITS);

  // Configuration register indexes.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_LOWEST  = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_HIGHEST = 1'd1;

  localparam logic [IDX_W-1:0] LOWEST_RST  = IDX_W'(1);
  localparam logic [IDX_W-1:0] HIGHEST_RST = IDX_W'(MAP_BITS - 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_ITEM,
    S_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic rd_scan;
    logic rd_item;
    logic eval_alloc;
    logic eval_item;
    logic reject;
    logic emit;
  } ba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    opcode_t op;
    logic    range_ok;
    logic    scan_done;
    logic    slot_free;
  } ba_sts_t;

endpackage

// ----- src/ba_if.sv -----
// Valid/ready channel interfaces of the bitmap allocator.
// Depends on ba_pkg for field types and widths.
interface ba_in_if;
  logic                     valid;
  logic                     ready;
  ba_pkg::opcode_t          opcode;
  logic [ba_pkg::IDX_W-1:0] index;

  modport source (output valid, output opcode, output index, input ready);
  modport sink   (input valid, input opcode, input index, output ready);
endinterface

interface ba_out_if;
  logic                     valid;
  logic                     ready;
  logic [ba_pkg::IDX_W-1:0] result_index;
  ba_pkg::status_t          status;
  logic                     bit_value;

  modport source (output valid, output result_index, output status, output bit_value,
                  input ready);
  modport sink   (input valid, input result_index, input status, input bit_value,
                  output ready);
endinterface

// ----- src/ba_ctrl.sv -----
// Sequencing state machine of the bitmap allocator.
// Depends on ba_pkg; drives ba_dp through the command struct.
module ba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ba_pkg::ba_sts_t sts,
  output ba_pkg::ba_cmd_t cmd
);

  ba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ba_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ba_pkg::S_DISPATCH;
      end
      ba_pkg::S_DISPATCH: begin
        case (sts.op)
          ba_pkg::OP_ALLOC: state_nxt = ba_pkg::S_SCAN;
          ba_pkg::OP_FREE:  state_nxt = sts.range_ok ? ba_pkg::S_ITEM : ba_pkg::S_EMIT;
          ba_pkg::OP_TEST:  state_nxt = ba_pkg::S_ITEM;
          default:          state_nxt = ba_pkg::S_EMIT;
        endcase
      end
      ba_pkg::S_SCAN: begin
        if (sts.scan_done) state_nxt = ba_pkg::S_EMIT;
      end
      ba_pkg::S_ITEM: begin
        state_nxt = ba_pkg::S_EMIT;
      end
      ba_pkg::S_EMIT: begin
        if (sts.slot_free) state_nxt = ba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ba_pkg::S_DISPATCH: begin
        case (sts.op)
          ba_pkg::OP_ALLOC: cmd.scan_start = 1'b1;
          ba_pkg::OP_FREE: begin
            cmd.rd_item = sts.range_ok;
            cmd.reject  = !sts.range_ok;
          end
          ba_pkg::OP_TEST:  cmd.rd_item = 1'b1;
          default:          cmd.reject  = 1'b1;
        endcase
      end
      ba_pkg::S_SCAN: begin
        cmd.rd_scan    = 1'b1;
        cmd.eval_alloc = sts.scan_done;
      end
      ba_pkg::S_ITEM: begin
        cmd.eval_item = 1'b1;
      end
      ba_pkg::S_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/ba_dp.sv -----
// Datapath of the bitmap allocator: limit registers, map memory, scan
// counter, result and output registers. Depends on ba_pkg.
module ba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ba_pkg::CFG_AW-1:0]       cfg_index,
  input  logic [ba_pkg::IDX_W-1:0]        cfg_wdata,
  input  ba_pkg::opcode_t                 in_opcode,
  input  logic [ba_pkg::IDX_W-1:0]        in_index,
  input  ba_pkg::ba_cmd_t                 cmd,
  output ba_pkg::ba_sts_t                 sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ba_pkg::IDX_W-1:0]        out_result_index,
  output ba_pkg::status_t                 out_status,
  output logic                            out_bit_value
);

  localparam logic [ba_pkg::WORD_AW-1:0] LAST_WORD = ba_pkg::WORD_AW'(ba_pkg::MAP_WORDS - 1);

  // Limits
  logic [ba_pkg::IDX_W-1:0] lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= ba_pkg::LOWEST_RST;
      hi_r <= ba_pkg::HIGHEST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ba_pkg::CFG_LOWEST:  lo_r <= cfg_wdata;
        ba_pkg::CFG_HIGHEST: hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched request
  ba_pkg::opcode_t          op_r;
  logic [ba_pkg::IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_index;
    end
  end

  // Map memory; an entry never written reads as all free
  logic [ba_pkg::WORD_BITS-1:0] mem [ba_pkg::MAP_WORDS];
  logic [ba_pkg::MAP_WORDS-1:0] wvalid_r;

  logic [ba_pkg::WORD_AW:0]     scan_cnt_r;
  logic                         rd_en;
  logic [ba_pkg::WORD_AW-1:0]   rd_addr;
  logic [ba_pkg::WORD_BITS-1:0] rdata_r;
  logic                         rhit_r;
  logic                         rd_vld_r;
  logic [ba_pkg::WORD_AW-1:0]   rd_word_r;

  logic                         wr_en;
  logic [ba_pkg::WORD_BITS-1:0] wr_data;
  logic [ba_pkg::WORD_AW-1:0]   wr_addr;

  assign rd_en   = (cmd.rd_scan && !scan_cnt_r[ba_pkg::WORD_AW]) || cmd.rd_item;
  assign rd_addr = cmd.rd_item ? idx_r[ba_pkg::IDX_W-1:ba_pkg::BIT_AW]
                               : scan_cnt_r[ba_pkg::WORD_AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rhit_r    <= wvalid_r[rd_addr];
      rd_word_r <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r   <= '0;
      rd_vld_r   <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      rd_vld_r <= rd_en;
      if (wr_en) wvalid_r[wr_addr] <= 1'b1;
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (cmd.rd_scan && !scan_cnt_r[ba_pkg::WORD_AW]) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
    end
  end

  // Word under inspection and its lowest clear bit
  logic [ba_pkg::WORD_BITS-1:0] word;
  logic                         has_zero;
  logic [ba_pkg::BIT_AW-1:0]    zpos;
  logic [ba_pkg::IDX_W-1:0]     found;
  logic [ba_pkg::BIT_AW-1:0]    ipos;

  assign word     = rhit_r ? rdata_r : '0;
  assign has_zero = ~&word;
  assign found    = {rd_word_r, zpos};
  assign ipos     = idx_r[ba_pkg::BIT_AW-1:0];

  always_comb begin
    zpos = '0;
    for (int i = ba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) zpos = ba_pkg::BIT_AW'(i);
    end
  end

  // Result evaluation and write-back
  logic [ba_pkg::IDX_W-1:0] res_idx_r;
  ba_pkg::status_t          res_st_r;
  logic                     res_bit_r;
  logic                     alloc_ok;

  assign alloc_ok = has_zero && (found <= hi_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_word_r;
    wr_data = word;
    if (cmd.eval_alloc && alloc_ok) begin
      wr_en   = 1'b1;
      wr_data = word | (ba_pkg::WORD_BITS'(1) << zpos);
    end else if (cmd.eval_item && op_r == ba_pkg::OP_FREE) begin
      wr_en   = 1'b1;
      wr_data = word & ~(ba_pkg::WORD_BITS'(1) << ipos);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_alloc) begin
      res_idx_r <= alloc_ok ? found : '0;
      res_st_r  <= alloc_ok ? ba_pkg::ST_OK : ba_pkg::ST_FULL;
      res_bit_r <= alloc_ok;
    end else if (cmd.eval_item) begin
      res_idx_r <= idx_r;
      res_st_r  <= ba_pkg::ST_OK;
      res_bit_r <= (op_r == ba_pkg::OP_TEST) ? word[ipos] : 1'b0;
    end else if (cmd.reject) begin
      res_idx_r <= idx_r;
      res_st_r  <= ba_pkg::ST_RANGE;
      res_bit_r <= 1'b0;
    end
  end

  // Output register
  logic                     out_valid_r;
  logic [ba_pkg::IDX_W-1:0] out_idx_r;
  ba_pkg::status_t          out_st_r;
  logic                     out_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r <= res_idx_r;
      out_st_r  <= res_st_r;
      out_bit_r <= res_bit_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_st_r;
  assign out_bit_value    = out_bit_r;

  assign sts.op        = op_r;
  assign sts.range_ok  = (idx_r >= lo_r) && (idx_r <= hi_r);
  assign sts.scan_done = rd_vld_r && (has_zero || rd_word_r == LAST_WORD);
  assign sts.slot_free = !out_valid_r || out_ready;

  a_wr_only_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cmd.eval_alloc || cmd.eval_item))
    else $error("map written outside an evaluation step");

  a_full_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ba_pkg::ST_FULL) |-> (out_idx_r == '0 && !out_bit_r))
    else $error("full result carries an index or bit");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");

  a_range_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ba_pkg::ST_RANGE) |-> !out_bit_r)
    else $error("rejected request reports a set bit");

endmodule

// ----- src/bitmap_allocator_unit.sv -----
// Top level of the first-fit bitmap allocator.
// Depends on ba_pkg, ba_if, ba_ctrl and ba_dp.
//
//   channel   dir  handshake        payload
//   in_chan   in   valid/ready      opcode[1:0], index[12:0]
//   out_chan  out  valid/ready      result_index[12:0], status[1:0], bit_value
//   cfg_*     in   cfg_we only      cfg_index[0], cfg_wdata[12:0]
//
// Allocate scans the map one 64-bit word per cycle through the single
// memory read port. Free and test pass through the dispatch, item and
// emit steps; an out-of-range free or an unused opcode skips the item step.
// Reset is synchronous, active low; per-word valid flags make the whole map
// read as free right after reset, with no clearing pass.
// A new transaction is taken while the previous result waits in the
// output register; a stalled output holds the block in its final step.
module bitmap_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ba_pkg::CFG_AW-1:0] cfg_index,
  input  logic [ba_pkg::IDX_W-1:0]  cfg_wdata,
  ba_in_if.sink                     in_chan,
  ba_out_if.source                  out_chan
);

  ba_pkg::ba_cmd_t cmd;
  ba_pkg::ba_sts_t sts;

  // Controller: one request at a time, from accept to output.
  ba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: limits, map, scan, results.
  ba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_opcode        (in_chan.opcode),
    .in_index         (in_chan.index),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_result_index (out_chan.result_index),
    .out_status       (out_chan.status),
    .out_bit_value    (out_chan.bit_value)
  );

endmodule

// ----- test/bitmap_allocator_unit_tb.sv -----
// Self-checking testbench for bitmap_allocator_unit: a shadow usage map predicts
// every answer, while directed, random and map-fill traffic runs under random stalls.
// Depends on ba_pkg, ba_if and the RTL of bitmap_allocator_unit.
module bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 4000; // cycles with no transaction before giving up
  localparam int SINK_HOLDOFF = 400;  // long receiver hold-off, in cycles
  localparam int WINDOW_TOP   = 383;  // index window where the allocated bits sit
  localparam int FILL_COUNT   = 300;  // back-to-back allocations of the fill phase

  // One expected answer of the block.
  typedef struct {
    logic [ba_pkg::IDX_W-1:0] index;
    ba_pkg::status_t          status;
    logic                     bit_value;
  } answer_t;

  // Shadow of the usage map and of both limit registers; predicts each answer
  // when a request is accepted and compares answers in arrival order.
  class alloc_checker;
    logic [ba_pkg::WORD_BITS-1:0] shadow_map [ba_pkg::MAP_WORDS];
    logic [ba_pkg::IDX_W-1:0]     lowest;
    logic [ba_pkg::IDX_W-1:0]     highest;
    answer_t                      answers_due [$];
    int                           bad_answers;

    function new();
      foreach (shadow_map[w]) shadow_map[w] = '0;
      lowest      = ba_pkg::LOWEST_RST;
      highest     = ba_pkg::HIGHEST_RST;
      bad_answers = 0;
    endfunction

    function void write_reg(logic [ba_pkg::CFG_AW-1:0] which,
                            logic [ba_pkg::IDX_W-1:0] value);
      if (which == ba_pkg::CFG_LOWEST) lowest = value;
      else highest = value;
    endfunction

    function void note_request(ba_pkg::opcode_t op, logic [ba_pkg::IDX_W-1:0] idx);
      answer_t a;
      int      hit;
      hit         = -1;
      a.index     = idx;
      a.status    = ba_pkg::ST_OK;
      a.bit_value = 1'b0;
      case (op)
        ba_pkg::OP_ALLOC: begin
          // first fit over the whole map; the lower limit does not apply
          for (int w = 0; w < ba_pkg::MAP_WORDS && hit < 0; w++)
            if (shadow_map[w] != '1)
              for (int b = 0; b < ba_pkg::WORD_BITS && hit < 0; b++)
                if (!shadow_map[w][b]) hit = w * ba_pkg::WORD_BITS + b;
          if (hit >= 0 && hit <= int'(highest)) begin
            shadow_map[hit / ba_pkg::WORD_BITS][hit % ba_pkg::WORD_BITS] = 1'b1;
            a.index     = hit[ba_pkg::IDX_W-1:0];
            a.bit_value = 1'b1;
          end else begin
            a.index  = '0;
            a.status = ba_pkg::ST_FULL;
          end
        end
        ba_pkg::OP_FREE: begin
          if (idx < lowest || idx > highest) a.status = ba_pkg::ST_RANGE;
          else shadow_map[idx[ba_pkg::IDX_W-1:ba_pkg::BIT_AW]][idx[ba_pkg::BIT_AW-1:0]] = 1'b0;
        end
        ba_pkg::OP_TEST:
          a.bit_value = shadow_map[idx[ba_pkg::IDX_W-1:ba_pkg::BIT_AW]][idx[ba_pkg::BIT_AW-1:0]];
        default: a.status = ba_pkg::ST_RANGE;
      endcase
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic [ba_pkg::IDX_W-1:0] index, ba_pkg::status_t status,
                               logic bit_value);
      answer_t a;
      if (answers_due.size() == 0) begin
        bad_answers++;
        if (bad_answers <= 10)
          $display("unexpected answer: index %0d status %0d bit %0b",
                   index, status, bit_value);
        return;
      end
      a = answers_due.pop_front();
      if (a.index !== index || a.status !== status || a.bit_value !== bit_value) begin
        bad_answers++;
        if (bad_answers <= 10)
          $display({"mismatch: index exp %0d got %0d, status exp %0d got %0d, ",
                    "bit exp %0b got %0b"},
                   a.index, index, a.status, status, a.bit_value, bit_value);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                      cfg_we;
  logic [ba_pkg::CFG_AW-1:0] cfg_index;
  logic [ba_pkg::IDX_W-1:0]  cfg_wdata;

  ba_in_if  in_chan ();
  ba_out_if out_chan ();

  alloc_checker tracker;
  bit calm;         // no idling on either side while set
  bit stall_req;    // asks the receiver for one long hold-off
  int quiet_cycles = 0;

  bitmap_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge. Check the answer first: an answer
  // never belongs to a request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tracker.check_answer(out_chan.result_index, out_chan.status, out_chan.bit_value);
    if (rst_n && in_chan.valid && in_chan.ready)
      tracker.note_request(in_chan.opcode, in_chan.index);
  end

  // Watchdog: count edges with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bitmap_allocator_unit regression: fail");
      $finish;
    end
  end

  // Receiver: drop ready at random about one time in five, hold it high while calm,
  // and once on request hold off for a long stretch so the block backs up.
  initial begin
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_chan.ready <= 1'b0;
        repeat (SINK_HOLDOFF) @(negedge clk);
        stall_req = 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // All stimulus tasks are entered at a falling edge with nothing yet driven
  // in that step, and return at a later falling edge in the same condition.

  // Offer one request, with an optional idle gap first; hold it until taken.
  task automatic send_request(ba_pkg::opcode_t op, logic [ba_pkg::IDX_W-1:0] idx);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 20) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.index  <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request. Without spread, most indexes fall in the low window where
  // allocations land, some next to the limits and a few anywhere; with spread,
  // indexes cover the whole map, which punches holes in a filled map.
  task automatic send_random(bit spread);
    ba_pkg::opcode_t          op;
    int                       pick;
    int                       v;
    logic [ba_pkg::IDX_W-1:0] base;
    pick = $urandom_range(99);
    if (pick < 40) op = ba_pkg::OP_ALLOC;
    else if (pick < 75) op = ba_pkg::OP_FREE;
    else if (pick < 95) op = ba_pkg::OP_TEST;
    else op = ba_pkg::OP_RSVD;
    pick = $urandom_range(99);
    if (pick < (spread ? 80 : 20)) begin
      v = $urandom_range(ba_pkg::MAP_BITS - 1);
    end else if (pick < (spread ? 100 : 35)) begin
      base = $urandom_range(1) ? tracker.lowest : tracker.highest;
      v = int'(base) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > ba_pkg::MAP_BITS - 1) v = ba_pkg::MAP_BITS - 1;
    end else begin
      v = $urandom_range(WINDOW_TOP);
    end
    send_request(op, v[ba_pkg::IDX_W-1:0]);
  endtask

  task automatic send_batch(int count, bit spread);
    repeat (count) send_random(spread);
  endtask

  // Stop offering and wait until every expected answer is back, then let the
  // block settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (tracker.answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both limits on an idle block, one register per cycle.
  task automatic reconfigure(logic [ba_pkg::IDX_W-1:0] lo, logic [ba_pkg::IDX_W-1:0] hi);
    drain();
    tracker.write_reg(ba_pkg::CFG_LOWEST, lo);
    tracker.write_reg(ba_pkg::CFG_HIGHEST, hi);
    cfg_we    <= 1'b1;
    cfg_index <= ba_pkg::CFG_LOWEST;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= ba_pkg::CFG_HIGHEST;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    tracker        = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ba_pkg::CFG_LOWEST;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.opcode = ba_pkg::OP_ALLOC;
    in_chan.index  = '0;
    calm           = 1'b0;
    stall_req      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset limits: lower limit 1, upper limit at the top of the map.
    send_request(ba_pkg::OP_TEST, '0);           // fresh map reads free
    send_request(ba_pkg::OP_FREE, '0);           // below the lower limit
    send_request(ba_pkg::OP_ALLOC, '0);          // takes bit 0
    send_request(ba_pkg::OP_TEST, '0);
    send_request(ba_pkg::OP_ALLOC, '1);          // index ignored, takes bit 1
    send_request(ba_pkg::OP_TEST, '1);
    send_request(ba_pkg::OP_FREE, 13'd1);
    send_request(ba_pkg::OP_FREE, 13'd1);        // freeing a free bit is fine
    send_request(ba_pkg::OP_TEST, 13'd1);
    send_request(ba_pkg::OP_FREE, '1);           // top index, inside the limits
    send_request(ba_pkg::OP_RSVD, '1);           // unused opcode
    send_request(ba_pkg::OP_RSVD, '0);
    send_request(ba_pkg::OP_ALLOC, '0);

    // Upper limit 0: the lowest free bit lies beyond it.
    reconfigure('0, '0);
    send_request(ba_pkg::OP_ALLOC, '0);
    send_request(ba_pkg::OP_FREE, 13'd1);        // above the upper limit
    send_request(ba_pkg::OP_FREE, '0);
    send_request(ba_pkg::OP_ALLOC, '0);          // bit 0 again, right at the limit
    send_request(ba_pkg::OP_ALLOC, '0);

    // Both limits at the top: allocate ignores the lower limit.
    reconfigure('1, '1);
    send_request(ba_pkg::OP_FREE, 13'd8190);
    send_request(ba_pkg::OP_FREE, '1);
    send_request(ba_pkg::OP_ALLOC, '0);
    send_request(ba_pkg::OP_TEST, 13'd2);
    send_request(ba_pkg::OP_ALLOC, '1);

    // Random traffic under several limit settings.
    reconfigure(ba_pkg::LOWEST_RST, ba_pkg::HIGHEST_RST);
    send_batch(100, 1'b0);

    // Hold the receiver off while requests keep coming, so the block backs up.
    reconfigure('0, '1);
    send_batch(80, 1'b0);
    stall_req = 1'b1;
    send_batch(120, 1'b0);

    // Tight upper limit: allocations soon run past it.
    reconfigure(ba_pkg::IDX_W'($urandom_range(50)), ba_pkg::IDX_W'($urandom_range(300, 60)));
    send_batch(120, 1'b0);

    // Lower limit above the upper one: every free is out of range.
    reconfigure(13'd100, 13'd50);
    send_batch(60, 1'b0);

    reconfigure(ba_pkg::IDX_W'($urandom_range(ba_pkg::MAP_BITS - 1)),
                ba_pkg::IDX_W'($urandom_range(ba_pkg::MAP_BITS - 1)));
    send_batch(80, 1'b0);

    // Pause the sender mid-phase until every answer is back.
    reconfigure('0, '1);
    send_batch(60, 1'b0);
    drain();
    send_batch(60, 1'b0);

    // Fill the low part of the map with no idling, so later scans walk
    // several words before they find a free bit.
    reconfigure('0, '1);
    calm = 1'b1;
    repeat (FILL_COUNT)
      send_request(ba_pkg::OP_ALLOC, ba_pkg::IDX_W'($urandom_range(ba_pkg::MAP_BITS - 1)));
    send_request(ba_pkg::OP_TEST, '0);
    send_request(ba_pkg::OP_TEST, '1);
    calm = 1'b0;

    // Free and reallocate across the map so scans end deeper in it.
    reconfigure(ba_pkg::IDX_W'($urandom_range(4000)), '1);
    send_batch(100, 1'b1);

    // Wait for the last answers plus the longest scan, then judge.
    drain();
    repeat (150) @(posedge clk);
    if (tracker.bad_answers == 0 && tracker.answers_due.size() == 0)
      $display("bitmap_allocator_unit regression: pass");
    else
      $display("bitmap_allocator_unit regression: fail");
    $finish;
  end

endmodule

// ----- bitmap_allocator_unit.f -----
src/ba_pkg.sv
src/ba_if.sv
src/ba_ctrl.sv
src/ba_dp.sv
src/bitmap_allocator_unit.sv
test/bitmap_allocator_unit_tb.sv
